// ----- hdl/ole_pkg.sv -----
// shared types and constants for the ordered list edit engine
// no dependencies; imported by every module of the block
`default_nettype none

package ole_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = 7;
  localparam int DW       = 32;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_DEL_AT    = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_DEL_MATCH = 3'd3,
    CMD_REPLACE   = 3'd4,
    CMD_REVERSE   = 3'd5,
    CMD_READ      = 3'd6,
    CMD_COUNT     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_WR,
    S_WR2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- hdl/ole_store.sv -----
// element store: one write port, two registered read ports
// depends on ole_pkg
`default_nettype none

module ole_store (
  input  wire logic             clk,
  input  wire ole_pkg::mem_req_t req,
  output logic [ole_pkg::DW-1:0] da,
  output logic [ole_pkg::DW-1:0] db
);
  import ole_pkg::*;

  logic [DW-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    // read data holds between reads so a swap can use it later
    if (req.re) begin
      da <= mem[req.raddr_a];
      db <= mem[req.raddr_b];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ole_seq.sv -----
// command sequencer with the shared compare unit and index counters
// depends on ole_pkg; drives the ole_store ports
`default_nettype none

module ole_seq (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [2:0]              command,
  input  wire logic [ole_pkg::CW-1:0]  position,
  input  wire logic [ole_pkg::DW-1:0]  value,
  input  wire logic [ole_pkg::DW-1:0]  replacement,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   status,
  output logic [ole_pkg::DW-1:0]       read_value,
  output logic [ole_pkg::CW-1:0]       match_count,
  output logic [ole_pkg::CW-1:0]       list_length,
  output ole_pkg::mem_req_t            req,
  input  wire logic [ole_pkg::DW-1:0]  da,
  input  wire logic [ole_pkg::DW-1:0]  db
);
  import ole_pkg::*;

  state_t        state, state_next;
  cmd_t          cmd, cmd_next;
  status_t       sts, sts_next;
  logic [CW-1:0] pos, pos_next;
  logic [DW-1:0] val, val_next;
  logic [DW-1:0] rep, rep_next;
  logic [CW-1:0] len, len_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [DW-1:0] rd, rd_next;

  logic [CW-1:0] i_p1, i_m1, j_p1, pos_m1, cap;
  logic [CW:0]   i_p2, len_p1;
  logic          hit;

  assign i_p1   = i + CW'(1);
  assign i_m1   = i - CW'(1);
  assign j_p1   = j + CW'(1);
  assign i_p2   = {1'b0, i} + (CW+1)'(2);
  assign pos_m1 = pos - CW'(1);
  assign len_p1 = {1'b0, len} + (CW+1)'(1);
  assign cap    = CW'(CAPACITY);
  // the shared compare unit
  assign hit    = (da == val);

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign status      = sts;
  assign read_value  = rd;
  assign match_count = cnt;
  assign list_length = len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    sts <= sts_next;
    pos <= pos_next;
    val <= val_next;
    rep <= rep_next;
    i   <= i_next;
    j   <= j_next;
    cnt <= cnt_next;
    rd  <= rd_next;
  end

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    sts_next   = sts;
    pos_next   = pos;
    val_next   = val;
    rep_next   = rep;
    len_next   = len;
    i_next     = i;
    j_next     = j;
    cnt_next   = cnt;
    rd_next    = rd;

    req.we      = 1'b0;
    req.waddr   = i[AW-1:0];
    req.wdata   = val;
    req.re      = 1'b0;
    req.raddr_a = i[AW-1:0];
    req.raddr_b = i[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_next   = cmd_t'(command);
          pos_next   = position;
          val_next   = value;
          rep_next   = replacement;
          sts_next   = ST_OK;
          rd_next    = '0;
          cnt_next   = '0;
          state_next = S_START;
        end
      end

      S_START: begin
        state_next = S_OUT;
        unique case (cmd)
          CMD_APPEND: begin
            if (len >= cap) begin
              sts_next = ST_FULL;
            end else begin
              req.we    = 1'b1;
              req.waddr = len[AW-1:0];
              req.wdata = val;
              len_next  = len + CW'(1);
            end
          end
          CMD_DEL_AT, CMD_READ: begin
            if (pos == '0 || pos > len) begin
              sts_next = ST_RANGE;
            end else begin
              i_next     = pos_m1;
              state_next = S_RD;
            end
          end
          CMD_INSERT: begin
            if (len >= cap) begin
              sts_next = ST_FULL;
            end else if (pos == '0 || {1'b0, pos} > len_p1) begin
              sts_next = ST_RANGE;
            end else if ({1'b0, pos} == len_p1) begin
              // insert just past the end needs no shifting
              req.we    = 1'b1;
              req.waddr = len[AW-1:0];
              req.wdata = val;
              len_next  = len + CW'(1);
            end else begin
              i_next     = len;
              state_next = S_RD;
            end
          end
          CMD_DEL_MATCH, CMD_REPLACE, CMD_COUNT: begin
            i_next = '0;
            j_next = '0;
            if (len != '0) begin
              state_next = S_RD;
            end
          end
          CMD_REVERSE: begin
            i_next = '0;
            j_next = len - CW'(1);
            if (len >= CW'(2)) begin
              state_next = S_RD;
            end
          end
          default: state_next = S_OUT;
        endcase
      end

      S_RD: begin
        req.re = 1'b1;
        if (cmd == CMD_DEL_AT) begin
          req.raddr_a = i_p1[AW-1:0];
        end else if (cmd == CMD_INSERT) begin
          req.raddr_a = i_m1[AW-1:0];
        end
        if (cmd == CMD_REVERSE) begin
          req.raddr_b = j[AW-1:0];
        end
        state_next = S_WR;
      end

      S_WR: begin
        state_next = S_OUT;
        unique case (cmd)
          CMD_READ: begin
            rd_next = db;
          end
          CMD_DEL_AT: begin
            if (i == pos_m1) begin
              rd_next = db;
            end
            if (i_p1 < len) begin
              req.we    = 1'b1;
              req.wdata = da;
            end
            if (i_p2 < {1'b0, len}) begin
              i_next     = i_p1;
              state_next = S_RD;
            end else begin
              len_next = len - CW'(1);
            end
          end
          CMD_INSERT: begin
            req.we    = 1'b1;
            req.wdata = da;
            if (i_m1 > pos_m1) begin
              i_next     = i_m1;
              state_next = S_RD;
            end else begin
              state_next = S_WR2;
            end
          end
          CMD_DEL_MATCH, CMD_REPLACE, CMD_COUNT: begin
            if (hit) begin
              cnt_next = cnt + CW'(1);
            end
            if (cmd == CMD_REPLACE && hit) begin
              req.we    = 1'b1;
              req.wdata = rep;
            end
            // compaction: survivors move down to the write index
            if (cmd == CMD_DEL_MATCH && !hit) begin
              req.we    = 1'b1;
              req.waddr = j[AW-1:0];
              req.wdata = da;
              j_next    = j_p1;
            end
            if (i_p1 < len) begin
              i_next     = i_p1;
              state_next = S_RD;
            end else if (cmd == CMD_DEL_MATCH) begin
              len_next = hit ? j : j_p1;
            end
          end
          CMD_REVERSE: begin
            req.we     = 1'b1;
            req.wdata  = db;
            state_next = S_WR2;
          end
          default: state_next = S_OUT;
        endcase
      end

      S_WR2: begin
        req.we = 1'b1;
        if (cmd == CMD_INSERT) begin
          req.waddr  = pos_m1[AW-1:0];
          req.wdata  = val;
          len_next   = len + CW'(1);
          state_next = S_OUT;
        end else begin
          // second half of a swap, low word still held in da
          req.waddr = j[AW-1:0];
          req.wdata = da;
          if (i_p2 < {1'b0, j}) begin
            i_next     = i_p1;
            j_next     = j - CW'(1);
            state_next = S_RD;
          end else begin
            state_next = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/ordered_list_edit_engine.sv -----
// top level of the ordered list edit engine: sequencer plus element store
// depends on ole_pkg, ole_seq and ole_store
//
// channel  | direction | handshake            | word
// ---------+-----------+----------------------+----------------------------------------
// in       | sink      | in_valid / in_ready  | command, position, value, replacement
// out      | source    | out_valid / out_ready| status, read_value, match_count, list_length
//
// one command at a time; in_ready is high only while idle
// append, refused commands and empty walks go from the start state straight to out_valid
// walks step through each entry as a registered read, then a write on the write port
// reverse swaps each pair through the read, write and second-write states
// reset clears the length and the sequencer; store contents are not cleared
// out_valid holds with the result until out_ready, then the block goes idle
`default_nettype none

module ordered_list_edit_engine (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [2:0]             command,
  input  wire logic [ole_pkg::CW-1:0] position,
  input  wire logic signed [31:0]     value,
  input  wire logic signed [31:0]     replacement,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  status,
  output logic signed [31:0]          read_value,
  output logic [ole_pkg::CW-1:0]      match_count,
  output logic [ole_pkg::CW-1:0]      list_length
);
  import ole_pkg::*;

  mem_req_t      req;
  logic [DW-1:0] da, db;
  logic [DW-1:0] rd_word;

  ole_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .position    (position),
    .value       (value),
    .replacement (replacement),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_value  (rd_word),
    .match_count (match_count),
    .list_length (list_length),
    .req         (req),
    .da          (da),
    .db          (db)
  );

  ole_store u_store (
    .clk (clk),
    .req (req),
    .da  (da),
    .db  (db)
  );

  assign read_value = rd_word;

endmodule

`default_nettype wire

// ----- hdl/ole_checker.sv -----
// port-level checks for ordered_list_edit_engine, attached by bind
// depends on ole_pkg
`default_nettype none

module ole_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [1:0]             status,
  input wire logic signed [31:0]     read_value,
  input wire logic [ole_pkg::CW-1:0] match_count,
  input wire logic [ole_pkg::CW-1:0] list_length
);
  import ole_pkg::*;

  // never taking a word while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // a result never shows right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("out_valid after reset");

  // list never grows past the store
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> list_length <= CW'(CAPACITY))
    else $error("list_length beyond capacity");

  // full only reported on a full list, and nothing removed with it
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |->
      (list_length == CW'(CAPACITY) && read_value == '0 && match_count == '0))
    else $error("full status with a non-full list");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) &&
      $stable(read_value) && $stable(match_count) && $stable(list_length)))
    else $error("result changed while stalled");

endmodule

bind ordered_list_edit_engine ole_checker u_ole_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .read_value  (read_value),
  .match_count (match_count),
  .list_length (list_length)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for ordered_list_edit_engine: directed edits, then random words
// depends on ole_pkg and the engine rtl; a tracker class mirrors the list and checks each result

module testbench;
  import ole_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;

  typedef struct {
    status_t              st;
    logic signed [DW-1:0] rd;
    logic [CW-1:0]        mc;
    logic [CW-1:0]        len;
  } list_result_t;

  // mirror of the stored list plus the result words still owed by the engine
  class list_tracker;
    logic signed [DW-1:0] entries[$];
    list_result_t         awaited[$];
    int                   mismatches;

    function int length();
      return entries.size();
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic signed [DW-1:0] entry_at(int idx);
      return entries[idx];
    endfunction

    function void note_command(cmd_t cmd, int pos, logic signed [DW-1:0] val,
                               logic signed [DW-1:0] rep);
      list_result_t         r;
      int                   n;
      logic signed [DW-1:0] kept[$];
      logic signed [DW-1:0] t;
      r.st = ST_OK;
      r.rd = '0;
      r.mc = '0;
      n = entries.size();
      case (cmd)
        CMD_APPEND: begin
          if (n >= CAPACITY) r.st = ST_FULL;
          else entries.push_back(val);
        end
        CMD_DEL_AT: begin
          if (pos < 1 || pos > n) begin
            r.st = ST_RANGE;
          end else begin
            r.rd = entries[pos-1];
            entries.delete(pos-1);
          end
        end
        CMD_INSERT: begin
          // full is reported ahead of a bad position
          if (n >= CAPACITY) r.st = ST_FULL;
          else if (pos < 1 || pos > n + 1) r.st = ST_RANGE;
          else entries.insert(pos-1, val);
        end
        CMD_DEL_MATCH: begin
          foreach (entries[i]) begin
            if (entries[i] == val) r.mc++;
            else kept.push_back(entries[i]);
          end
          entries = kept;
        end
        CMD_REPLACE: begin
          foreach (entries[i]) begin
            if (entries[i] == val) begin
              entries[i] = rep;
              r.mc++;
            end
          end
        end
        CMD_REVERSE: begin
          for (int i = 0; i < n / 2; i++) begin
            t = entries[i];
            entries[i] = entries[n-1-i];
            entries[n-1-i] = t;
          end
        end
        CMD_READ: begin
          if (pos < 1 || pos > n) r.st = ST_RANGE;
          else r.rd = entries[pos-1];
        end
        default: begin
          foreach (entries[i]) if (entries[i] == val) r.mc++;
        end
      endcase
      r.len = CW'(entries.size());
      awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic signed [DW-1:0] rd,
                               logic [CW-1:0] mc, logic [CW-1:0] len);
      list_result_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d read %0d count %0d length %0d",
                   st, rd, mc, len);
        return;
      end
      e = awaited.pop_front();
      if (st !== e.st || rd !== e.rd || mc !== e.mc || len !== e.len) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp status %0d read %0d count %0d len %0d, got %0d %0d %0d %0d",
                   e.st, e.rd, e.mc, e.len, st, rd, mc, len);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           command;
  logic [CW-1:0]        position;
  logic signed [DW-1:0] value;
  logic signed [DW-1:0] replacement;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           status;
  logic signed [DW-1:0] read_value;
  logic [CW-1:0]        match_count;
  logic [CW-1:0]        list_length;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off;
  list_tracker tracker = new();

  ordered_list_edit_engine u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .position    (position),
    .value       (value),
    .replacement (replacement),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_value  (read_value),
    .match_count (match_count),
    .list_length (list_length)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: ready changes on the falling edge, a long hold-off drains hold_off first
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        hold_off--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result(status, read_value, match_count, list_length);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // offer one command word; returns at the edge that accepts it
  task automatic send_word(cmd_t cmd, int pos, logic signed [DW-1:0] val,
                           logic signed [DW-1:0] rep);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    command     = cmd;
    position    = pos[CW-1:0];
    value       = val;
    replacement = rep;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_command(cmd, pos, val, rep);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // often values already in the list so the match commands find something
  function automatic logic signed [DW-1:0] pick_value(int len);
    int r;
    r = $urandom_range(0, 99);
    if (len > 0 && r < 40) return tracker.entry_at($urandom_range(0, len - 1));
    if (r < 65) begin
      case ($urandom_range(0, 4))
        0: return 32'sd0;
        1: return -32'sd1;
        2: return 32'sh7fffffff;
        3: return 32'sh80000000;
        default: return 32'sd7;
      endcase
    end
    return $urandom;
  endfunction

  task automatic random_burst(mix_t mix, int items);
    cmd_t                 c;
    int                   r;
    int                   len;
    int                   hi;
    int                   pos;
    logic signed [DW-1:0] v;
    logic signed [DW-1:0] rep;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      case (mix)
        MIX_GROW:
          c = (r < 55) ? CMD_APPEND : (r < 85) ? CMD_INSERT : (r < 90) ? CMD_READ :
              (r < 94) ? CMD_COUNT : (r < 97) ? CMD_REPLACE : (r < 99) ? CMD_REVERSE :
              CMD_DEL_AT;
        MIX_SHRINK:
          c = (r < 40) ? CMD_DEL_AT : (r < 60) ? CMD_DEL_MATCH : (r < 70) ? CMD_READ :
              (r < 78) ? CMD_COUNT : (r < 84) ? CMD_REVERSE : (r < 90) ? CMD_REPLACE :
              (r < 95) ? CMD_APPEND : CMD_INSERT;
        default:
          c = cmd_t'($urandom_range(0, 7));
      endcase
      len = tracker.length();
      hi  = (c == CMD_INSERT) ? len + 1 : len;
      r   = $urandom_range(0, 99);
      if (r < 80 && hi >= 1) pos = $urandom_range(1, hi);
      else if (r < 90) pos = (r < 85) ? 0 : hi + 1;
      else pos = $urandom_range(0, 127);
      v   = pick_value(len);
      rep = pick_value(len);
      send_word(c, pos, v, rep);
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    command       = CMD_APPEND;
    position      = '0;
    value         = '0;
    replacement   = '0;
    send_idle_pct = 26;
    recv_idle_pct = 72;
    hold_off      = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty list: every position is out of range
    send_word(CMD_READ, 1, 32'sd0, 32'sd0);
    send_word(CMD_DEL_AT, 0, 32'sd0, 32'sd0);
    send_word(CMD_REVERSE, 0, 32'sd0, 32'sd0);
    send_word(CMD_APPEND, 0, 32'sh7fffffff, 32'sd0);
    send_word(CMD_REVERSE, 0, 32'sd0, 32'sd0);
    send_word(CMD_APPEND, 0, 32'sh80000000, 32'sd0);
    send_word(CMD_INSERT, 1, 32'sd0, 32'sd0);
    send_word(CMD_INSERT, 4, -32'sd1, 32'sd0);
    send_word(CMD_INSERT, 6, 32'sd5, 32'sd0);
    send_word(CMD_INSERT, 0, 32'sd5, 32'sd0);
    send_word(CMD_APPEND, 0, -32'sd1, 32'sd0);
    send_word(CMD_APPEND, 0, -32'sd1, 32'sd0);
    send_word(CMD_COUNT, 0, -32'sd1, 32'sd0);
    send_word(CMD_REPLACE, 0, 32'sd0, 32'sh80000000);
    send_word(CMD_REVERSE, 0, 32'sd0, 32'sd0);
    send_word(CMD_READ, 1, 32'sd0, 32'sd0);
    send_word(CMD_READ, 6, 32'sd0, 32'sd0);
    send_word(CMD_READ, 7, 32'sd0, 32'sd0);
    send_word(CMD_READ, 127, 32'sd0, 32'sd0);
    send_word(CMD_DEL_AT, 127, 32'sd0, 32'sd0);
    // three adjacent matches at the head after the reverse
    send_word(CMD_DEL_MATCH, 0, -32'sd1, 32'sd0);
    send_word(CMD_DEL_AT, 1, 32'sd0, 32'sd0);
    send_word(CMD_DEL_AT, 2, 32'sd0, 32'sd0);
    send_word(CMD_DEL_MATCH, 0, 32'sd12345, 32'sd0);
    send_word(CMD_REPLACE, 0, 32'sd12345, -32'sd2);

    random_burst(MIX_GROW, 100);
    random_burst(MIX_BALANCED, 80);
    random_burst(MIX_SHRINK, 50);

    send_idle_pct = 72;
    recv_idle_pct = 26;
    random_burst(MIX_GROW, 100);
    wait_drained();
    random_burst(MIX_BALANCED, 80);
    random_burst(MIX_SHRINK, 50);

    // no idling; receiver stalls for a long stretch while words keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off      = 300;
    random_burst(MIX_GROW, 100);
    random_burst(MIX_BALANCED, 80);
    random_burst(MIX_SHRINK, 50);

    wait_drained();
    repeat (200) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ole_pkg.sv
hdl/ole_store.sv
hdl/ole_seq.sv
hdl/ordered_list_edit_engine.sv
hdl/ole_checker.sv
tb/sv/testbench.sv
